// ===== design/hid_boot_report_to_ascii_top_assert.svh =====
// Assertion macros used by the keyboard report translator merge module
`ifndef HID_BOOT_REPORT_TO_ASCII_TOP_ASSERT_SVH
`define HID_BOOT_REPORT_TO_ASCII_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Checked outside reset
`define HBRA_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("hbra assertion failed");
// Checked at every edge, reset included
`define HBRA_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("hbra reset assertion failed");
`else
`define HBRA_ASSERT(lbl, clk, rstn, prop)
`define HBRA_ASSERT_RST(lbl, clk, prop)
`endif

`endif

// ===== design/hbra_pkg.sv =====
// Types, constants and character ROMs for the keyboard report translator
`timescale 1ns / 1ps

package hbra_pkg;

    localparam int KEY_SLOTS = 6;
    localparam int IN_KEYS   = 6;

    localparam logic [7:0] MOD_CTRL_MASK  = 8'h11;
    localparam logic [7:0] MOD_SHIFT_MASK = 8'h22;

    typedef logic [7:0] key_t;
    typedef logic [6:0] char_t;
    typedef key_t  [KEY_SLOTS-1:0] key_vec_t;
    typedef char_t [KEY_SLOTS-1:0] char_vec_t;

    typedef struct packed {
        logic  hit;
        char_t ch;
    } lane_res_t;

    // Captured lane results of one report
    typedef struct packed {
        logic                 valid;
        logic [KEY_SLOTS-1:0] hit;
        char_vec_t            ch;
    } cap_t;

    function automatic char_t rom_plain(input logic [6:0] idx);
        char_t c;
        c = '0;
        if (idx >= 7'h04 && idx <= 7'h1D) begin
            c = 7'h61 + (idx - 7'h04);
        end else if (idx >= 7'h1E && idx <= 7'h26) begin
            c = 7'h31 + (idx - 7'h1E);
        end else if (idx >= 7'h59 && idx <= 7'h61) begin
            c = 7'h31 + (idx - 7'h59);
        end else begin
            unique case (idx)
                7'h27: c = 7'h30;
                7'h28: c = 7'h0A;
                7'h29: c = 7'h1B;
                7'h2A: c = 7'h08;
                7'h2B: c = 7'h09;
                7'h2C: c = 7'h20;
                7'h2D: c = 7'h2D;
                7'h2E: c = 7'h3D;
                7'h2F: c = 7'h5B;
                7'h30: c = 7'h5D;
                7'h31: c = 7'h5C;
                7'h33: c = 7'h3B;
                7'h34: c = 7'h27;
                7'h35: c = 7'h60;
                7'h36: c = 7'h2C;
                7'h37: c = 7'h2E;
                7'h38: c = 7'h2F;
                7'h54: c = 7'h2F;
                7'h55: c = 7'h2A;
                7'h56: c = 7'h2D;
                7'h57: c = 7'h2B;
                7'h58: c = 7'h0A;
                7'h62: c = 7'h30;
                7'h63: c = 7'h2E;
                default: c = '0;
            endcase
        end
        return c;
    endfunction

    function automatic char_t rom_shift(input logic [6:0] idx);
        char_t c;
        c = '0;
        if (idx >= 7'h04 && idx <= 7'h1D) begin
            c = 7'h41 + (idx - 7'h04);
        end else begin
            unique case (idx)
                7'h1E: c = 7'h21;
                7'h1F: c = 7'h40;
                7'h20: c = 7'h23;
                7'h21: c = 7'h24;
                7'h22: c = 7'h25;
                7'h23: c = 7'h5E;
                7'h24: c = 7'h26;
                7'h25: c = 7'h2A;
                7'h26: c = 7'h28;
                7'h27: c = 7'h29;
                7'h28: c = 7'h0A;
                7'h29: c = 7'h1B;
                7'h2A: c = 7'h08;
                7'h2B: c = 7'h09;
                7'h2C: c = 7'h20;
                7'h2D: c = 7'h5F;
                7'h2E: c = 7'h2B;
                7'h2F: c = 7'h7B;
                7'h30: c = 7'h7D;
                7'h31: c = 7'h7C;
                7'h33: c = 7'h3A;
                7'h34: c = 7'h22;
                7'h35: c = 7'h7E;
                7'h36: c = 7'h3C;
                7'h37: c = 7'h3E;
                7'h38: c = 7'h3F;
                default: c = '0;
            endcase
        end
        return c;
    endfunction

endpackage

// ===== design/hbra_lane.sv =====
// One key slot: new-press detection and character translation
`timescale 1ns / 1ps

module hbra_lane (
    input  hbra_pkg::key_t      code_i,
    input  logic                shift_i,
    input  logic                ctrl_i,
    input  hbra_pkg::key_vec_t  prev_i,
    output hbra_pkg::lane_res_t res_o
);
    import hbra_pkg::*;

    logic  seen;
    char_t raw;
    char_t ch;
    logic  is_letter;

    always_comb begin
        seen = 1'b0;
        for (int i = 0; i < KEY_SLOTS; i++) begin
            if (prev_i[i] == code_i) begin
                seen = 1'b1;
            end
        end
    end

    assign raw = shift_i ? rom_shift(code_i[6:0]) : rom_plain(code_i[6:0]);

    assign is_letter = (raw >= 7'h61 && raw <= 7'h7A) || (raw >= 7'h41 && raw <= 7'h5A);

    // Ctrl folds both letter cases onto 1..26
    assign ch = (ctrl_i && is_letter) ? {2'b00, raw[4:0]} : raw;

    assign res_o.hit = (code_i != '0) && !code_i[7] && !seen && (ch != '0);
    assign res_o.ch  = ch;

endmodule

// ===== design/hbra_merge.sv =====
// Merge stage: emit the captured lane characters in slot order
`timescale 1ns / 1ps
`include "hid_boot_report_to_ascii_top_assert.svh"

module hbra_merge (
    input  logic                aclk,
    input  logic                aresetn,
    input  hbra_pkg::cap_t      cap_i,
    output logic                take_o,
    output logic                m_valid,
    input  logic                m_ready,
    output hbra_pkg::char_t     m_ascii_char,
    output logic                m_last_of_run
);
    import hbra_pkg::*;

    logic [KEY_SLOTS-1:0] mask_reg, mask_next;
    char_vec_t            ch_reg, ch_next;
    logic [KEY_SLOTS-1:0] low_bit;
    logic [KEY_SLOTS-1:0] rest;
    logic                 free;
    char_t                sel;

    assign low_bit = mask_reg & (-mask_reg);
    assign rest    = mask_reg & ~low_bit;

    assign m_valid       = (mask_reg != '0);
    assign m_last_of_run = (rest == '0);

    // Reload when empty or once the final character is leaving
    assign free   = !m_valid || (m_ready && m_last_of_run);
    assign take_o = cap_i.valid && free;

    always_comb begin
        sel = '0;
        for (int i = 0; i < KEY_SLOTS; i++) begin
            if (low_bit[i]) begin
                sel = sel | ch_reg[i];
            end
        end
    end

    assign m_ascii_char = sel;

    always_comb begin
        mask_next = mask_reg;
        ch_next   = ch_reg;
        priority if (take_o) begin
            mask_next = cap_i.hit;
            ch_next   = cap_i.ch;
        end else if (m_valid && m_ready) begin
            mask_next = rest;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0;
        end else begin
            mask_reg <= mask_next;
        end
        ch_reg <= ch_next;
    end

    `HBRA_ASSERT(a_char_nonzero, aclk, aresetn, m_valid |-> (m_ascii_char != '0))
    `HBRA_ASSERT(a_run_continues, aclk, aresetn, (m_valid && m_ready && !m_last_of_run) |=> m_valid)
    `HBRA_ASSERT_RST(a_reset_empty, aclk, !aresetn |=> !m_valid)

endmodule

// ===== design/hid_boot_report_to_ascii_top.sv =====
// Keyboard boot report to ASCII translator, top level
// An accepted item passes through the capture register and then the merge register, whence its characters leave.
// Throughput: one character per cycle while m_ready is high; the merge register takes the next
// item as the last character of the current one leaves.
// The six lanes look up all slots at once against the stored previous codes.
// Reset (aresetn, synchronous, active low) clears the previous codes and empties both stages.
`timescale 1ns / 1ps

module hid_boot_report_to_ascii_top (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  hbra_pkg::key_t  s_modifiers,
    input  hbra_pkg::key_t  s_key_a,
    input  hbra_pkg::key_t  s_key_b,
    input  hbra_pkg::key_t  s_key_c,
    input  hbra_pkg::key_t  s_key_d,
    input  hbra_pkg::key_t  s_key_e,
    input  hbra_pkg::key_t  s_key_f,
    output logic            m_valid,
    input  logic            m_ready,
    output hbra_pkg::char_t m_ascii_char,
    output logic            m_last_of_run
);
    import hbra_pkg::*;

    key_t      in_keys [IN_KEYS];
    key_vec_t  codes;
    key_vec_t  prev_reg;
    lane_res_t lane_res [KEY_SLOTS];
    cap_t      cap_reg, cap_next;
    logic      shift, ctrl, accept, take;

    assign in_keys[0] = s_key_a;
    assign in_keys[1] = s_key_b;
    assign in_keys[2] = s_key_c;
    assign in_keys[3] = s_key_d;
    assign in_keys[4] = s_key_e;
    assign in_keys[5] = s_key_f;

    assign shift = |(s_modifiers & MOD_SHIFT_MASK);
    assign ctrl  = |(s_modifiers & MOD_CTRL_MASK);

    assign s_ready = !cap_reg.valid || take;
    assign accept  = s_valid && s_ready;

    for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_lane
        // Slots past the report's fields read as no key
        if (g < IN_KEYS) begin : g_in
            assign codes[g] = in_keys[g];
        end else begin : g_zero
            assign codes[g] = '0;
        end

        hbra_lane u_lane (
            .code_i  (codes[g]),
            .shift_i (shift),
            .ctrl_i  (ctrl),
            .prev_i  (prev_reg),
            .res_o   (lane_res[g])
        );
    end

    always_comb begin
        cap_next = cap_reg;
        if (take) begin
            cap_next.valid = 1'b0;
        end
        if (accept) begin
            cap_next.valid = 1'b1;
            for (int i = 0; i < KEY_SLOTS; i++) begin
                cap_next.hit[i] = lane_res[i].hit;
                cap_next.ch[i]  = lane_res[i].ch;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg  <= '0;
            prev_reg <= '0;
        end else begin
            cap_reg <= cap_next;
            // Store raw codes at once so the next item compares against them
            if (accept) begin
                prev_reg <= codes;
            end
        end
    end

    hbra_merge u_merge (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cap_i         (cap_reg),
        .take_o        (take),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_ascii_char  (m_ascii_char),
        .m_last_of_run (m_last_of_run)
    );

endmodule
